// ===== hdl/qpd_pkg.sv =====
// shared types, constants and helper functions for the quoted-printable decoder
// no dependencies; used by qpd_ctrl, qpd_datapath and the top level
package qpd_pkg;

    localparam int WS_HOLD_DEPTH = 32;
    localparam int CNT_W         = $clog2(WS_HOLD_DEPTH + 1);
    localparam int IDX_W         = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [1:0] STAT_DATA = 2'd0;
    localparam logic [1:0] STAT_ERR  = 2'd1;
    localparam logic [1:0] STAT_EOS  = 2'd2;

    typedef enum logic [2:0] {
        ST_PLAIN   = 3'd0,
        ST_WS      = 3'd1,
        ST_EQ      = 3'd2,
        ST_HEX2    = 3'd3,
        ST_SOFT_LF = 3'd4,
        ST_HARD_LF = 3'd5,
        ST_ERR     = 3'd6
    } dec_state_t;

    typedef enum logic {
        PH_RUN   = 1'b0,
        PH_FLUSH = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        EMIT_IN   = 3'd0,
        EMIT_HEX  = 3'd1,
        EMIT_CR   = 3'd2,
        EMIT_LF   = 3'd3,
        EMIT_ERR  = 3'd4,
        EMIT_EOS  = 3'd5,
        EMIT_HELD = 3'd6,
        EMIT_PEND = 3'd7
    } emit_sel_t;

    typedef struct packed {
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      hold_first;
        logic      hold_push;
        logic      hold_clear;
        logic      nib_load;
        logic      pend_load;
        logic      pend_lf;
        logic      pend_clear;
        logic      flush_start;
        logic      flush_step;
    } qpd_cmd_t;

    typedef struct packed {
        logic is_eq;
        logic is_cr;
        logic is_lf;
        logic is_ws;
        logic hex_ok;
        logic count_zero;
        logic count_full;
        logic held_left;
        logic idx_last;
        logic pend_valid;
        logic out_free;
        logic lb_mode;
    } qpd_stat_t;

    // {valid, nibble}; only 0-9 and A-F are digits
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

// ===== hdl/qpd_ctrl.sv =====
// decode and flush state machine of the quoted-printable decoder
// depends on qpd_pkg; drives qpd_datapath through qpd_cmd_t
module qpd_ctrl import qpd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  qpd_stat_t stat,
    output qpd_cmd_t  cmd
);

    dec_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       accept;

    assign s_tready = (phase_reg == PH_RUN) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PLAIN;
            phase_reg <= PH_RUN;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        if (phase_reg == PH_FLUSH) begin
            if (stat.out_free && (!stat.held_left || (stat.idx_last && !stat.pend_valid))) begin
                phase_next = PH_RUN;
            end
        end else if (accept) begin
            if (!(state_reg inside {ST_PLAIN, ST_WS, ST_EQ, ST_HEX2, ST_SOFT_LF,
                                    ST_HARD_LF})) begin
                state_next = ST_ERR;
            end else if (s_tlast) begin
                if (!stat.count_zero) begin
                    state_next = ST_ERR;
                end
            end else begin
                case (state_reg)
                    ST_PLAIN: begin
                        if (stat.is_eq) begin
                            state_next = ST_EQ;
                        end else if (stat.is_cr) begin
                            state_next = ST_HARD_LF;
                        end else if (stat.is_ws) begin
                            state_next = ST_WS;
                        end
                    end
                    ST_WS: begin
                        if (stat.is_ws) begin
                            if (stat.count_full) begin
                                state_next = ST_ERR;
                            end
                        end else if (stat.is_eq) begin
                            state_next = ST_EQ;
                        end else if (stat.is_cr) begin
                            state_next = ST_HARD_LF;
                        end else begin
                            state_next = ST_PLAIN;
                            phase_next = PH_FLUSH;
                        end
                    end
                    ST_EQ: begin
                        if (stat.is_cr) begin
                            state_next = ST_SOFT_LF;
                        end else if (!stat.hex_ok) begin
                            state_next = ST_ERR;
                        end else begin
                            state_next = ST_HEX2;
                            if (!stat.count_zero) begin
                                phase_next = PH_FLUSH;
                            end
                        end
                    end
                    ST_HEX2: begin
                        state_next = stat.hex_ok ? ST_PLAIN : ST_ERR;
                    end
                    ST_SOFT_LF: begin
                        if (stat.is_lf) begin
                            state_next = ST_PLAIN;
                            if (!stat.count_zero) begin
                                phase_next = PH_FLUSH;
                            end
                        end else begin
                            state_next = ST_ERR;
                        end
                    end
                    ST_HARD_LF: begin
                        if (stat.is_lf) begin
                            state_next = ST_PLAIN;
                            if (!stat.lb_mode) begin
                                phase_next = PH_FLUSH;
                            end
                        end else begin
                            state_next = ST_ERR;
                        end
                    end
                    default: state_next = ST_ERR;
                endcase
            end
        end
    end

    // datapath commands
    always_comb begin
        cmd = '0;
        cmd.emit_sel = EMIT_IN;
        if (phase_reg == PH_FLUSH) begin
            if (stat.out_free) begin
                cmd.emit = 1'b1;
                if (stat.held_left) begin
                    cmd.emit_sel   = EMIT_HELD;
                    cmd.emit_last  = stat.idx_last && !stat.pend_valid;
                    cmd.flush_step = 1'b1;
                    cmd.hold_clear = stat.idx_last && !stat.pend_valid;
                end else begin
                    cmd.emit_sel   = EMIT_PEND;
                    cmd.emit_last  = 1'b1;
                    cmd.pend_clear = 1'b1;
                    cmd.hold_clear = 1'b1;
                end
            end
        end else if (accept) begin
            if (!(state_reg inside {ST_PLAIN, ST_WS, ST_EQ, ST_HEX2, ST_SOFT_LF,
                                    ST_HARD_LF})) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = EMIT_ERR;
                cmd.emit_last = 1'b1;
            end else if (s_tlast) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = stat.count_zero ? EMIT_EOS : EMIT_ERR;
                cmd.emit_last = 1'b1;
            end else begin
                case (state_reg)
                    ST_PLAIN: begin
                        if (stat.is_ws) begin
                            cmd.hold_first = 1'b1;
                        end else if (!stat.is_eq && !stat.is_cr) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = EMIT_IN;
                            cmd.emit_last = 1'b1;
                        end
                    end
                    ST_WS: begin
                        if (stat.is_ws) begin
                            if (stat.count_full) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_sel  = EMIT_ERR;
                                cmd.emit_last = 1'b1;
                            end else begin
                                cmd.hold_push = 1'b1;
                            end
                        end else if (stat.is_cr) begin
                            cmd.hold_clear = 1'b1;
                        end else if (!stat.is_eq) begin
                            cmd.pend_load   = 1'b1;
                            cmd.flush_start = 1'b1;
                        end
                    end
                    ST_EQ: begin
                        if (!stat.is_cr) begin
                            if (!stat.hex_ok) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_sel  = EMIT_ERR;
                                cmd.emit_last = 1'b1;
                            end else begin
                                cmd.nib_load    = 1'b1;
                                cmd.flush_start = !stat.count_zero;
                            end
                        end
                    end
                    ST_HEX2: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = stat.hex_ok ? EMIT_HEX : EMIT_ERR;
                        cmd.emit_last = 1'b1;
                    end
                    ST_SOFT_LF: begin
                        if (stat.is_lf) begin
                            cmd.flush_start = !stat.count_zero;
                        end else begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = EMIT_ERR;
                            cmd.emit_last = 1'b1;
                        end
                    end
                    ST_HARD_LF: begin
                        cmd.emit = 1'b1;
                        if (!stat.is_lf) begin
                            cmd.emit_sel  = EMIT_ERR;
                            cmd.emit_last = 1'b1;
                        end else if (stat.lb_mode) begin
                            cmd.emit_sel  = EMIT_LF;
                            cmd.emit_last = 1'b1;
                        end else begin
                            cmd.emit_sel    = EMIT_CR;
                            cmd.pend_load   = 1'b1;
                            cmd.pend_lf     = 1'b1;
                            cmd.flush_start = 1'b1;
                        end
                    end
                    default: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_ERR;
                        cmd.emit_last = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/qpd_datapath.sv =====
// datapath: whitespace hold buffer, escape nibble, pending byte and output register
// depends on qpd_pkg; controlled by qpd_ctrl
module qpd_datapath import qpd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  qpd_cmd_t   cmd,
    output qpd_stat_t  stat,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [1:0] m_tuser,
    output logic       m_tlast
);

    logic             lb_mode_reg;
    logic [3:0]       nib_reg, nib_next;
    logic             ws_tab_reg [WS_HOLD_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_last_reg;
    logic [4:0]       hex;
    logic [7:0]       held_byte;

    assign hex       = hex_decode(in_byte);
    assign held_byte = ws_tab_reg[idx_reg[IDX_W-1:0]] ? CH_TAB : CH_SP;

    assign stat.is_eq      = (in_byte == CH_EQ);
    assign stat.is_cr      = (in_byte == CH_CR);
    assign stat.is_lf      = (in_byte == CH_LF);
    assign stat.is_ws      = (in_byte == CH_SP) || (in_byte == CH_TAB);
    assign stat.hex_ok     = hex[4];
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CNT_W'(WS_HOLD_DEPTH));
    assign stat.held_left  = (idx_reg != count_reg);
    assign stat.idx_last   = ((idx_reg + CNT_W'(1)) == count_reg);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.lb_mode    = lb_mode_reg;

    always_comb begin
        nib_next = cmd.nib_load ? hex[3:0] : nib_reg;

        count_next = count_reg;
        if (cmd.hold_clear) begin
            count_next = '0;
        end else if (cmd.hold_first) begin
            count_next = CNT_W'(1);
        end else if (cmd.hold_push) begin
            count_next = count_reg + CNT_W'(1);
        end

        idx_next = idx_reg;
        if (cmd.flush_start) begin
            idx_next = '0;
        end else if (cmd.flush_step) begin
            idx_next = idx_reg + CNT_W'(1);
        end

        pend_valid_next = pend_valid_reg;
        if (cmd.pend_load) begin
            pend_valid_next = 1'b1;
        end else if (cmd.pend_clear) begin
            pend_valid_next = 1'b0;
        end

        out_status_next = STAT_DATA;
        case (cmd.emit_sel)
            EMIT_IN:   out_byte_next = in_byte;
            EMIT_HEX:  out_byte_next = {nib_reg, hex[3:0]};
            EMIT_CR:   out_byte_next = CH_CR;
            EMIT_LF:   out_byte_next = CH_LF;
            EMIT_ERR: begin
                out_byte_next   = 8'h00;
                out_status_next = STAT_ERR;
            end
            EMIT_EOS: begin
                out_byte_next   = 8'h00;
                out_status_next = STAT_EOS;
            end
            EMIT_HELD: out_byte_next = held_byte;
            EMIT_PEND: out_byte_next = pend_byte_reg;
            default:   out_byte_next = 8'h00;
        endcase

        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lb_mode_reg    <= 1'b0;
            nib_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lb_mode_reg <= cfg_wr_data;
            end
            nib_reg        <= nib_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold buffer keeps one bit per entry: tab or space
    always_ff @(posedge aclk) begin
        if (cmd.hold_first) begin
            ws_tab_reg[0] <= (in_byte == CH_TAB);
        end else if (cmd.hold_push) begin
            ws_tab_reg[count_reg[IDX_W-1:0]] <= (in_byte == CH_TAB);
        end
        if (cmd.pend_load) begin
            pend_byte_reg <= cmd.pend_lf ? CH_LF : in_byte;
        end
        if (cmd.emit) begin
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/quoted_printable_decoder_unit.sv =====
// Quoted-printable decoder: one encoded byte per item in, zero or more decoded items out.
// A byte is taken only while the output register is free and no flush is under way. A byte
// that releases held whitespace is followed by each held space or tab in order, and then by
// a trailing plain byte, if any; a hard break in CR LF mode gives CR and then LF. Input
// stalls until the last of these is loaded into the single output register.
// Errors are sticky until reset.
// depends on qpd_pkg, qpd_ctrl and qpd_datapath
module quoted_printable_decoder_unit import qpd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // line_break_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // in_byte
    input  logic       s_tlast,       // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_byte
    output logic [1:0] m_tuser,       // status
    output logic       m_tlast        // last
);

    qpd_cmd_t  cmd;
    qpd_stat_t stat;

    qpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qpd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("item accepted while output register blocked");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_ERR)) |-> m_tlast)
        else $error("error item not marked last");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (m_tuser == STAT_ERR)) |=>
            (!m_tvalid || (m_tuser == STAT_ERR)))
        else $error("non-error item after error");

    a_no_flush_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input taken in the middle of a multi-item result");
`endif

endmodule
